@@ hw/rtl/segdc_pkg.sv @@
// ----------------------------------------------------------------------------
// segdc_pkg
// Shared constants and controller/datapath command and status types for the
// segment to disc clipper.
// ----------------------------------------------------------------------------
package segdc_pkg;

  localparam int COORD_W = 16;
  localparam int REG_W   = 12;
  localparam int K_W     = 5;
  localparam int ACC_W   = 70;

  // Probe steps of one pull-back and the rounding offset of k/20
  localparam logic [K_W-1:0] K_START    = 5'd20;
  localparam logic [K_W-1:0] K_LAST     = 5'd1;
  localparam logic [21:0]    ROUND_HALF = 22'd10;

  // Divide by five: floor(m * RECIP_5 / 2^21), exact for m below 699050
  localparam logic [20:0] RECIP_5 = 21'd419431;

  // Configuration register indexes
  localparam logic [1:0] REG_CENTER_X = 2'd0;
  localparam logic [1:0] REG_CENTER_Y = 2'd1;
  localparam logic [1:0] REG_RADIUS   = 2'd2;

  // Point selection for the inside test
  localparam logic [1:0] PT_P0    = 2'd0;
  localparam logic [1:0] PT_P1    = 2'd1;
  localparam logic [1:0] PT_PROBE = 2'd2;

  typedef struct packed {
    logic           load;
    logic           in_a;
    logic [1:0]     pt_sel;
    logic           in_b;
    logic           in_c;
    logic           cr_a;
    logic           cr_b;
    logic           cr_c;
    logic           mac_clr;
    logic           mac_step;
    logic [2:0]     mac_idx;
    logic           side;
    logic           delta;
    logic           pr_a;
    logic [K_W-1:0] k;
    logic           pr_b;
    logic           hit;
    logic           collapse;
    logic           emit;
    logic           emit_vis;
  } segdc_cmd_t;

  typedef struct packed {
    logic in0;
    logic in1;
    logic probe_in;
    logic cross_skip;
    logic acc_neg;
  } segdc_status_t;

endpackage

@@ hw/rtl/segdc_datapath.sv @@
// ----------------------------------------------------------------------------
// segdc_datapath
// Configuration registers, endpoint registers, inside test, exact crossing
// test by partial-product accumulation, probe generation and result register.
// ----------------------------------------------------------------------------
module segdc_datapath (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr,
  input  logic [1:0]                 cfg_index,
  input  logic [segdc_pkg::REG_W-1:0] cfg_data,
  input  logic [63:0]                s_tdata,
  input  segdc_pkg::segdc_cmd_t      cmd,
  output segdc_pkg::segdc_status_t   status,
  output logic [63:0]                m_tdata,
  output logic                       m_tuser
);
  import segdc_pkg::*;

  logic [REG_W-1:0] center_x, center_y, disc_radius;
  logic [23:0] r2;
  logic signed [COORD_W-1:0] x0, y0, x1, y1;

  // inside test
  logic [1:0] tsel;
  logic signed [COORD_W-1:0] tx, ty;
  logic signed [17:0] ex, ey;
  logic [31:0] sqx, sqy;
  logic signed [COORD_W-1:0] px, py;
  logic signed [35:0] sqx_full, sqy_full;
  logic [32:0] dist2;
  logic in0, in1, probe_in;

  // crossing test
  logic signed [16:0] cdx, cdy;
  logic signed [17:0] cfx, cfy;
  logic signed [33:0] pa_x_full, pa_y_full;
  logic signed [34:0] ph_x_full, ph_y_full;
  logic signed [35:0] pc_x_full, pc_y_full;
  logic [32:0] pa_x, pa_y;
  logic signed [34:0] ph_x, ph_y;
  logic [31:0] pc_x, pc_y;
  logic [33:0] a, c, u;
  logic signed [35:0] h, neg_h;
  logic signed [ACC_W-1:0] acc;
  logic [33:0] op1, op2;
  logic [16:0] half1, half2;
  logic [33:0] prod;
  logic [ACC_W-1:0] prod_sh;

  // probes
  logic signed [COORD_W-1:0] fix_x, fix_y, mov_x, mov_y;
  logic signed [16:0] dd_x, dd_y;
  logic [16:0] ad_x, ad_y;
  logic [21:0] n_x, n_y;
  logic dneg_x, dneg_y;
  logic [40:0] qp_x, qp_y;
  logic [16:0] q_x, q_y;
  logic signed [17:0] off_x, off_y, prb_x, prb_y;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      center_x    <= REG_W'(120);
      center_y    <= REG_W'(120);
      disc_radius <= REG_W'(100);
    end else if (cfg_wr) begin
      case (cfg_index)
        REG_CENTER_X: center_x    <= cfg_data;
        REG_CENTER_Y: center_y    <= cfg_data;
        REG_RADIUS:   disc_radius <= cfg_data;
        default: ;
      endcase
    end
  end

  // Select fixed and moving endpoint of the current pull-back
  assign fix_x = cmd.side ? x1 : x0;
  assign fix_y = cmd.side ? y1 : y0;
  assign mov_x = cmd.side ? x0 : x1;
  assign mov_y = cmd.side ? y0 : y1;

  // Form the probe point from the rounded offset
  assign off_x = dneg_x ? -$signed({1'b0, q_x}) : $signed({1'b0, q_x});
  assign off_y = dneg_y ? -$signed({1'b0, q_y}) : $signed({1'b0, q_y});
  assign prb_x = {{2{fix_x[COORD_W-1]}}, fix_x} + off_x;
  assign prb_y = {{2{fix_y[COORD_W-1]}}, fix_y} + off_y;

  always_comb begin
    case (cmd.pt_sel)
      PT_P0: begin
        px = x0;
        py = y0;
      end
      PT_P1: begin
        px = x1;
        py = y1;
      end
      default: begin
        px = prb_x[COORD_W-1:0];
        py = prb_y[COORD_W-1:0];
      end
    endcase
  end

  assign sqx_full = ex * ex;
  assign sqy_full = ey * ey;
  assign dist2    = {1'b0, sqx} + {1'b0, sqy};

  assign pa_x_full = cdx * cdx;
  assign pa_y_full = cdy * cdy;
  assign ph_x_full = cfx * cdx;
  assign ph_y_full = cfy * cdy;
  assign pc_x_full = cfx * cfx;
  assign pc_y_full = cfy * cfy;

  assign neg_h = -h;

  // Pick halves for one partial product of u*u or a*c
  assign op1   = cmd.mac_idx[2] ? a : u;
  assign op2   = cmd.mac_idx[2] ? c : u;
  assign half1 = cmd.mac_idx[1] ? op1[33:17] : op1[16:0];
  assign half2 = cmd.mac_idx[0] ? op2[33:17] : op2[16:0];
  assign prod  = half1 * half2;

  always_comb begin
    case (cmd.mac_idx[1:0])
      2'b00:   prod_sh = {36'b0, prod};
      2'b11:   prod_sh = {2'b0, prod, 34'b0};
      default: prod_sh = {19'b0, prod, 17'b0};
    endcase
  end

  assign ad_x = dd_x[16] ? 17'(-dd_x) : 17'(dd_x);
  assign ad_y = dd_y[16] ? 17'(-dd_y) : 17'(dd_y);
  assign qp_x = {21'b0, n_x[21:2]} * {20'b0, RECIP_5};
  assign qp_y = {21'b0, n_y[21:2]} * {20'b0, RECIP_5};

  // Sequence the datapath operations
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x0 <= $signed(s_tdata[15:0]);
      y0 <= $signed(s_tdata[31:16]);
      x1 <= $signed(s_tdata[47:32]);
      y1 <= $signed(s_tdata[63:48]);
      r2 <= {12'b0, disc_radius} * {12'b0, disc_radius};
    end
    if (cmd.in_a) begin
      tsel <= cmd.pt_sel;
      tx   <= px;
      ty   <= py;
      ex   <= {{2{px[COORD_W-1]}}, px} - $signed({6'b0, center_x});
      ey   <= {{2{py[COORD_W-1]}}, py} - $signed({6'b0, center_y});
    end
    if (cmd.in_b) begin
      sqx <= sqx_full[31:0];
      sqy <= sqy_full[31:0];
    end
    if (cmd.in_c) begin
      case (tsel)
        PT_P0:   in0      <= (dist2 <= {9'b0, r2});
        PT_P1:   in1      <= (dist2 <= {9'b0, r2});
        default: probe_in <= (dist2 <= {9'b0, r2});
      endcase
    end
    if (cmd.cr_a) begin
      cdx <= {x1[COORD_W-1], x1} - {x0[COORD_W-1], x0};
      cdy <= {y1[COORD_W-1], y1} - {y0[COORD_W-1], y0};
      cfx <= {{2{x0[COORD_W-1]}}, x0} - $signed({6'b0, center_x});
      cfy <= {{2{y0[COORD_W-1]}}, y0} - $signed({6'b0, center_y});
    end
    if (cmd.cr_b) begin
      pa_x <= pa_x_full[32:0];
      pa_y <= pa_y_full[32:0];
      ph_x <= ph_x_full;
      ph_y <= ph_y_full;
      pc_x <= pc_x_full[31:0];
      pc_y <= pc_y_full[31:0];
    end
    if (cmd.cr_c) begin
      a <= {1'b0, pa_x} + {1'b0, pa_y};
      h <= {ph_x[34], ph_x} + {ph_y[34], ph_y};
      c <= {2'b0, pc_x} + {2'b0, pc_y} - {10'b0, r2};
    end
    if (cmd.mac_clr) begin
      acc <= '0;
      u   <= neg_h[33:0];
    end
    if (cmd.mac_step) begin
      if (cmd.mac_idx[2]) acc <= acc - $signed(prod_sh);
      else acc <= acc + $signed(prod_sh);
    end
    if (cmd.delta) begin
      dd_x <= {mov_x[COORD_W-1], mov_x} - {fix_x[COORD_W-1], fix_x};
      dd_y <= {mov_y[COORD_W-1], mov_y} - {fix_y[COORD_W-1], fix_y};
    end
    if (cmd.pr_a) begin
      n_x    <= ({5'b0, ad_x} * {17'b0, cmd.k}) + ROUND_HALF;
      n_y    <= ({5'b0, ad_y} * {17'b0, cmd.k}) + ROUND_HALF;
      dneg_x <= dd_x[16];
      dneg_y <= dd_y[16];
    end
    if (cmd.pr_b) begin
      q_x <= qp_x[37:21];
      q_y <= qp_y[37:21];
    end
    // Move the endpoint onto the hit probe or collapse it
    if (cmd.hit || cmd.collapse) begin
      if (cmd.side) begin
        x0 <= cmd.hit ? tx : x1;
        y0 <= cmd.hit ? ty : y1;
      end else begin
        x1 <= cmd.hit ? tx : x0;
        y1 <= cmd.hit ? ty : y0;
      end
    end
    if (cmd.emit) begin
      m_tuser <= cmd.emit_vis;
      m_tdata <= cmd.emit_vis ? {y1, x1, y0, x0} : 64'b0;
    end
  end

  assign status.in0        = in0;
  assign status.in1        = in1;
  assign status.probe_in   = probe_in;
  assign status.cross_skip = (a == 34'b0) || (!h[35] && (h != 36'sb0)) ||
                             (neg_h > $signed({2'b0, a}));
  assign status.acc_neg    = acc[ACC_W-1];

endmodule

@@ hw/rtl/segdc_ctrl.sv @@
// ----------------------------------------------------------------------------
// segdc_ctrl
// Sequencer: endpoint tests, crossing test, two pull-backs of up to twenty
// probes each, and the output valid flag.
// ----------------------------------------------------------------------------
module segdc_ctrl (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output segdc_pkg::segdc_cmd_t    cmd,
  input  segdc_pkg::segdc_status_t status
);
  import segdc_pkg::*;

  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_P0A  = 5'd1;
  localparam logic [4:0] ST_P0B  = 5'd2;
  localparam logic [4:0] ST_P0C  = 5'd3;
  localparam logic [4:0] ST_P1A  = 5'd4;
  localparam logic [4:0] ST_P1B  = 5'd5;
  localparam logic [4:0] ST_P1C  = 5'd6;
  localparam logic [4:0] ST_DEC  = 5'd7;
  localparam logic [4:0] ST_CRA  = 5'd8;
  localparam logic [4:0] ST_CRB  = 5'd9;
  localparam logic [4:0] ST_CRC  = 5'd10;
  localparam logic [4:0] ST_CRD  = 5'd11;
  localparam logic [4:0] ST_MAC  = 5'd12;
  localparam logic [4:0] ST_MACE = 5'd13;
  localparam logic [4:0] ST_PLS  = 5'd14;
  localparam logic [4:0] ST_PRA  = 5'd15;
  localparam logic [4:0] ST_PRB  = 5'd16;
  localparam logic [4:0] ST_TA   = 5'd17;
  localparam logic [4:0] ST_TB   = 5'd18;
  localparam logic [4:0] ST_TC   = 5'd19;
  localparam logic [4:0] ST_TCHK = 5'd20;
  localparam logic [4:0] ST_EMIT = 5'd21;

  logic [4:0] state, state_next;
  logic [K_W-1:0] k, k_next;
  logic [2:0] mac_i, mac_i_next;
  logic side, side_next;
  logic vis, vis_next;
  logic mov_in;

  assign s_tready = (state == ST_IDLE);
  assign mov_in   = side ? status.in0 : status.in1;

  always_comb begin
    cmd        = '0;
    cmd.side   = side;
    cmd.k      = k;
    cmd.mac_idx = mac_i;
    cmd.emit_vis = vis;
    state_next = state;
    k_next     = k;
    mac_i_next = mac_i;
    side_next  = side;
    vis_next   = vis;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = ST_P0A;
        end
      end
      ST_P0A: begin
        cmd.in_a   = 1'b1;
        cmd.pt_sel = PT_P0;
        state_next = ST_P0B;
      end
      ST_P0B: begin
        cmd.in_b   = 1'b1;
        state_next = ST_P0C;
      end
      ST_P0C: begin
        cmd.in_c   = 1'b1;
        state_next = ST_P1A;
      end
      ST_P1A: begin
        cmd.in_a   = 1'b1;
        cmd.pt_sel = PT_P1;
        state_next = ST_P1B;
      end
      ST_P1B: begin
        cmd.in_b   = 1'b1;
        state_next = ST_P1C;
      end
      ST_P1C: begin
        cmd.in_c   = 1'b1;
        state_next = ST_DEC;
      end
      // Either endpoint inside: go straight to clipping
      ST_DEC: begin
        side_next = 1'b0;
        if (status.in0 || status.in1) state_next = ST_PLS;
        else state_next = ST_CRA;
      end
      ST_CRA: begin
        cmd.cr_a   = 1'b1;
        state_next = ST_CRB;
      end
      ST_CRB: begin
        cmd.cr_b   = 1'b1;
        state_next = ST_CRC;
      end
      ST_CRC: begin
        cmd.cr_c   = 1'b1;
        state_next = ST_CRD;
      end
      // Drop degenerate segments and those whose vertex lies off the span
      ST_CRD: begin
        if (status.cross_skip) begin
          vis_next   = 1'b0;
          state_next = ST_EMIT;
        end else begin
          cmd.mac_clr = 1'b1;
          mac_i_next  = 3'd0;
          state_next  = ST_MAC;
        end
      end
      ST_MAC: begin
        cmd.mac_step = 1'b1;
        mac_i_next   = mac_i + 3'd1;
        if (mac_i == 3'd7) state_next = ST_MACE;
      end
      ST_MACE: begin
        side_next = 1'b0;
        if (status.acc_neg) begin
          vis_next   = 1'b0;
          state_next = ST_EMIT;
        end else begin
          state_next = ST_PLS;
        end
      end
      // Start a pull-back unless the moving endpoint is already inside
      ST_PLS: begin
        if (mov_in) begin
          if (side) begin
            vis_next   = 1'b1;
            state_next = ST_EMIT;
          end else begin
            side_next = 1'b1;
          end
        end else begin
          cmd.delta  = 1'b1;
          k_next     = K_START;
          state_next = ST_PRA;
        end
      end
      ST_PRA: begin
        cmd.pr_a   = 1'b1;
        state_next = ST_PRB;
      end
      ST_PRB: begin
        cmd.pr_b   = 1'b1;
        state_next = ST_TA;
      end
      ST_TA: begin
        cmd.in_a   = 1'b1;
        cmd.pt_sel = PT_PROBE;
        state_next = ST_TB;
      end
      ST_TB: begin
        cmd.in_b   = 1'b1;
        state_next = ST_TC;
      end
      ST_TC: begin
        cmd.in_c   = 1'b1;
        state_next = ST_TCHK;
      end
      // Take the hit, collapse after the last probe, or advance k
      ST_TCHK: begin
        if (status.probe_in || (k == K_LAST)) begin
          cmd.hit      = status.probe_in;
          cmd.collapse = !status.probe_in;
          if (side) begin
            vis_next   = 1'b1;
            state_next = ST_EMIT;
          end else begin
            side_next  = 1'b1;
            state_next = ST_PLS;
          end
        end else begin
          k_next     = k - K_LAST;
          state_next = ST_PRA;
        end
      end
      ST_EMIT: begin
        if (!m_tvalid || m_tready) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      k        <= K_START;
      mac_i    <= 3'd0;
      side     <= 1'b0;
      vis      <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      k     <= k_next;
      mac_i <= mac_i_next;
      side  <= side_next;
      vis   <= vis_next;
      if (cmd.emit) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!m_tvalid || m_tready))
    else $error("result overwritten while pending");

  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> m_tvalid)
    else $error("result not presented after emit");

  a_k_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PRA) |-> ((k != 5'd0) && (k <= K_START)))
    else $error("probe step out of range");

endmodule

@@ hw/rtl/segment_disc_clipper_top.sv @@
// With both endpoints inside, the result is registered without any probe; a segment
// dropped by the crossing test skips the pull-backs, and each of the two pull-backs
// runs up to twenty probes.
// Throughput: one item at a time; the next item is taken once the result is
// registered, while that result may still wait at the output.
// Reset: synchronous, active high; clears control, disc at (120,120) radius 100.
// ----------------------------------------------------------------------------
// segment_disc_clipper_top
// Clips a screen-space line segment against a configured disc.
// ----------------------------------------------------------------------------
module segment_disc_clipper_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // start_x, start_y, end_x, end_y
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // clipped_start_x, clipped_start_y,
                                 // clipped_end_x, clipped_end_y
  output logic        m_tuser,   // visible
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_data
);
  import segdc_pkg::*;

  segdc_cmd_t    cmd;
  segdc_status_t status;

  assign cfg_ready = 1'b1;

  segdc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .status   (status)
  );

  segdc_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr    (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .cmd       (cmd),
    .status    (status),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule

@@ dv/segment_disc_clipper_top_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_disc_clipper_top_test
// Drives line segments into the disc clipper under several disc settings and
// idle patterns, predicts each clipped result and compares it field by field.
// ----------------------------------------------------------------------------
import segdc_pkg::*;

class clip_scoreboard;
  logic [64:0] pending[$];
  int          mismatches;
  int          checked;
  longint      cx, cy, rad;

  function new();
    cx = 120; cy = 120; rad = 100;
    mismatches = 0; checked = 0;
  endfunction

  function bit in_disc(longint x, longint y);
    longint ox, oy;
    ox = x - cx; oy = y - cy;
    return ox * ox + oy * oy <= rad * rad;
  endfunction

  function bit passes_disc(longint x0, longint y0, longint x1, longint y1);
    longint dx, dy, a, fx, fy, h, c;
    logic signed [129:0] hh, ac;
    if (in_disc(x0, y0) || in_disc(x1, y1)) return 1;
    dx = x1 - x0; dy = y1 - y0;
    a = dx * dx + dy * dy;
    if (a == 0) return 0;
    fx = x0 - cx; fy = y0 - cy;
    h = fx * dx + fy * dy;
    c = fx * fx + fy * fy - rad * rad;
    if (h > 0 || -h > a) return 0;
    hh = 130'(h) * 130'(h);
    ac = 130'(a) * 130'(c);
    return hh >= ac;
  endfunction

  function longint round20(longint n);
    if (n >= 0) return (n + 10) / 20;
    return -((-n + 10) / 20);
  endfunction

  // Walk the moving point back toward the fixed one in twentieths
  function void pull_back(longint fx, longint fy, inout longint mx, inout longint my);
    longint dx, dy, px, py;
    if (in_disc(mx, my)) return;
    dx = mx - fx; dy = my - fy;
    for (int k = 20; k >= 1; k--) begin
      px = fx + round20(dx * k);
      py = fy + round20(dy * k);
      if (in_disc(px, py)) begin
        mx = px; my = py;
        return;
      end
    end
    mx = fx; my = fy;
  endfunction

  function void set_reg(logic [1:0] idx, logic [11:0] v);
    case (idx)
      REG_CENTER_X: cx = v;
      REG_CENTER_Y: cy = v;
      REG_RADIUS:   rad = v;
      default: ;
    endcase
  endfunction

  function void note_segment(logic [63:0] d);
    longint x0, y0, x1, y1;
    x0 = $signed(d[15:0]); y0 = $signed(d[31:16]);
    x1 = $signed(d[47:32]); y1 = $signed(d[63:48]);
    if (!passes_disc(x0, y0, x1, y1)) begin
      pending.push_back(65'd0);
    end else begin
      pull_back(x0, y0, x1, y1);
      pull_back(x1, y1, x0, y0);
      pending.push_back({1'b1, y1[15:0], x1[15:0], y0[15:0], x0[15:0]});
    end
  endfunction

  function void report(string what, logic [63:0] got, logic [63:0] want);
    mismatches++;
    $display("error: %s got %h want %h", what, got, want);
  endfunction

  function void check_result(logic vis, logic [63:0] d);
    logic [64:0] e;
    checked++;
    if (pending.size() == 0) begin
      report("unexpected result", d, 0);
      return;
    end
    e = pending.pop_front();
    if (vis !== e[64]) report("visible", 64'(vis), 64'(e[64]));
    for (int f = 0; f < 4; f++)
      if (d[f*16 +: 16] !== e[f*16 +: 16])
        report($sformatf("coord field %0d", f), 64'(d[f*16 +: 16]), 64'(e[f*16 +: 16]));
  endfunction
endclass

module segment_disc_clipper_top_test;
  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [63:0] m_tdata;
  logic        m_tuser;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [11:0] cfg_data = '0;

  clip_scoreboard sb = new();
  int send_idle = 0;
  int recv_stall = 0;
  int quiet = 0;
  int sent = 0;

  segment_disc_clipper_top dut (.*);

  always #5 clk = ~clk;

  // Receiver: randomly stall, check every result transfer
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata);
  end
  always @(negedge clk) m_tready <= ($urandom_range(99) >= recv_stall);

  // Watchdog on cycles with no transfer at all
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready) || rst)
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet > 20000) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Valid stays up after a transfer until the next segment or an idle gap drops it
  task automatic push_segment(logic [63:0] d);
    if ($urandom_range(99) < send_idle) begin
      s_tvalid <= 0;
      @(negedge clk);
      while ($urandom_range(99) < send_idle) @(negedge clk);
    end
    s_tvalid <= 1;
    s_tdata  <= d;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_segment(d);
    sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [11:0] v);
    cfg_valid <= 1; cfg_index <= idx; cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, v);
    @(negedge clk);
    cfg_valid <= 0;
    @(negedge clk);
  endtask

  function automatic logic [15:0] near(longint c, int spread);
    return 16'(c + $signed($urandom_range(2 * spread)) - spread);
  endfunction

  // Mostly segments near the disc, some anywhere in the coordinate range
  task automatic random_segments(int n);
    logic [63:0] d;
    int sp;
    for (int i = 0; i < n; i++) begin
      sp = int'(sb.rad) * (1 + $urandom_range(3));
      if ($urandom_range(9) < 8)
        d = {near(sb.cy, sp), near(sb.cx, sp), near(sb.cy, sp), near(sb.cx, sp)};
      else
        d = {$urandom(), $urandom()};
      push_segment(d);
    end
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst <= 0;
    @(negedge clk);
    // Directed: extremes, inside, tangent, zero length, pass-through
    push_segment({16'sd120, 16'sd120, 16'sd120, 16'sd120});
    push_segment({16'sd0, 16'sd0, 16'sd0, 16'sd0});
    push_segment({16'h7fff, 16'h7fff, 16'h8000, 16'h8000});
    push_segment({16'h8000, 16'h7fff, 16'h7fff, 16'h8000});
    push_segment({16'sd220, 16'sd400, 16'sd220, -16'sd200});
    push_segment({16'sd300, -16'sd100, -16'sd100, 16'sd300});
    push_segment({16'sd120, 16'sd500, 16'sd120, -16'sd300});
    push_segment({16'sd130, 16'sd130, 16'sd900, 16'sd900});
    push_segment({16'sd900, 16'sd900, 16'sd130, 16'sd130});
    push_segment({16'sd221, 16'sd221, 16'sd221, 16'sd221});
    push_segment({16'hffff, 16'hffff, 16'hffff, 16'hffff});
    drain();
    write_reg(REG_RADIUS, 12'd1);
    write_reg(REG_CENTER_X, 12'd0);
    write_reg(REG_CENTER_Y, 12'd0);
    push_segment({16'sd0, 16'sd1, 16'sd0, -16'sd1});
    push_segment({16'sd5, 16'sd5, -16'sd5, -16'sd5});
    push_segment({16'sd0, 16'sd0, 16'sd0, 16'sd0});
    drain();
    // Random phases under several disc settings and idle patterns
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin write_reg(REG_CENTER_X, 12'd120); write_reg(REG_CENTER_Y, 12'd120);
                 write_reg(REG_RADIUS, 12'd100); end
        1: begin write_reg(REG_CENTER_X, 12'hfff); write_reg(REG_CENTER_Y, 12'hfff);
                 write_reg(REG_RADIUS, 12'hfff); end
        2: begin write_reg(REG_CENTER_X, 12'd0); write_reg(REG_CENTER_Y, 12'hfff);
                 write_reg(REG_RADIUS, 12'd3); end
        default: begin
          write_reg(REG_CENTER_X, 12'($urandom())); write_reg(REG_CENTER_Y, 12'($urandom()));
          write_reg(REG_RADIUS, 12'($urandom_range(4095, 1)));
        end
      endcase
      case (ph % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 66; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 66; end
        default: begin send_idle = 27; recv_stall = 27; end
      endcase
      random_segments(36);
      // Hold the sender until everything outstanding has come back
      s_tvalid <= 0;
      while (sb.pending.size() != 0) @(negedge clk);
      random_segments(36);
      drain();
    end
    recv_stall = 0;
    drain();
    $display("covered %0d segments, %0d results, disc corners and tiny radii", sent, sb.checked);
    if (sb.mismatches == 0 && sb.pending.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

@@ segment_disc_clipper_top.f @@
hw/rtl/segdc_pkg.sv
hw/rtl/segdc_datapath.sv
hw/rtl/segdc_ctrl.sv
hw/rtl/segment_disc_clipper_top.sv
dv/segment_disc_clipper_top_test.sv
